@@ rtl/crbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_pkg
// Shared widths, codes and the operation record passed from the classifier
// to the executor of the cartridge ROM bus mapper.
// ----------------------------------------------------------------------------
package crbm_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned OFF_W      = 22;
  localparam int unsigned SIZE_W     = 23;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam int unsigned ROM_BYTES_DEF  = 524288;
  localparam int unsigned FIFO_DEPTH_DEF = 2;
  localparam int unsigned MENU_BYTES     = 1024;
  localparam int unsigned MENU_AW        = 10;

  // menu table window 0x7000..0x73ff, trigger window 0x7400..0x740f
  localparam logic [OFF_W-MENU_AW-1:0] MENU_WIN = 12'h01c;
  localparam logic [OFF_W-SEL_W-1:0]   TRIG_WIN = 18'h00740;

  localparam logic [BYTE_W-1:0] BYTE_UNMAPPED = 8'hff;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROM  = 2'd0,
    CMD_LOAD_MENU = 2'd1,
    CMD_BUS_READ  = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOROM     = 2'd0,
    MODE_HIROM     = 2'd1,
    MODE_MENU      = 2'd2,
    MODE_LOROM_ALT = 2'd3
  } map_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_MODE    = 2'd0,
    REG_ROM_SIZE    = 2'd1,
    REG_ENTRY_COUNT = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_LOAD_ROM  = 3'd0,
    OP_LOAD_MENU = 3'd1,
    OP_RD_ROM    = 3'd2,
    OP_RD_MENU   = 3'd3,
    OP_RD_FF     = 3'd4,
    OP_SELECT    = 3'd5,
    OP_RD_BLANK  = 3'd6
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [OFF_W-1:0]    addr;
    logic [BYTE_W-1:0]   data;
    logic [SEL_W-1:0]    sel_idx;
  } op_t;

endpackage

@@ rtl/crbm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm channel interfaces
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crbm_in_if;
  import crbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ADDR_W-1:0]   address;
  logic [BYTE_W-1:0]   load_data;
  modport source (output valid, output command, output address, output load_data,
                  input ready);
  modport sink   (input valid, input command, input address, input load_data,
                  output ready);
endinterface

interface crbm_out_if;
  import crbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic                drive;
  logic                selected;
  logic [SEL_W-1:0]    selected_index;
  modport source (output valid, output read_data, output drive, output selected,
                  output selected_index, input ready);
  modport sink   (input valid, input read_data, input drive, input selected,
                  input selected_index, output ready);
endinterface

interface crbm_cfg_if;
  import crbm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/crbm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_front
// Takes commands and register writes, maps bus addresses and classifies each
// load and bus read into an executor operation; unused commands are dropped.
// ----------------------------------------------------------------------------
module crbm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  crbm_in_if.sink        in_ch,
  crbm_cfg_if.sink       cfg_ch,
  input  logic           full_i,
  output logic           push_o,
  output crbm_pkg::op_t  op_o
);
  import crbm_pkg::*;

  logic [MODE_W-1:0] map_mode_q, map_mode_d;
  logic [SIZE_W-1:0] rom_size_q, rom_size_d;
  logic [SEL_W-1:0]  entry_count_q, entry_count_d;
  logic              sel_done_q, sel_done_d;

  logic [7:0]        bank;
  logic [OFF_W-1:0]  off;
  logic              hirom, menu, in_menu_win, in_trig, in_rom, accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !full_i;
  assign accept       = in_ch.valid && !full_i;

  always_comb begin
    map_mode_d    = map_mode_q;
    rom_size_d    = rom_size_q;
    entry_count_d = entry_count_q;
    if (cfg_ch.valid) begin
      case (cfg_reg_e'(cfg_ch.addr))
        REG_MAP_MODE:    map_mode_d    = cfg_ch.data[MODE_W-1:0];
        REG_ROM_SIZE:    rom_size_d    = cfg_ch.data[SIZE_W-1:0];
        REG_ENTRY_COUNT: entry_count_d = cfg_ch.data[SEL_W-1:0];
        default:         ;
      endcase
    end
  end

  assign bank  = in_ch.address[ADDR_W-1:16];
  assign hirom = (map_mode_e'(map_mode_q) == MODE_HIROM);
  assign menu  = (map_mode_e'(map_mode_q) == MODE_MENU);
  assign off   = hirom ? {bank[5:0], in_ch.address[15:0]}
                       : {bank[6:0], in_ch.address[14:0]};

  assign in_menu_win = menu && (off[OFF_W-1:MENU_AW] == MENU_WIN);
  assign in_trig     = menu && (off[OFF_W-1:SEL_W] == TRIG_WIN)
                       && (off[SEL_W-1:0] < entry_count_q);
  assign in_rom      = ({1'b0, off} < rom_size_q);

  always_comb begin
    push_o       = 1'b0;
    op_o.kind    = OP_RD_BLANK;
    op_o.addr    = off;
    op_o.data    = in_ch.load_data;
    op_o.sel_idx = '0;
    case (cmd_e'(in_ch.command))
      CMD_LOAD_ROM: begin
        push_o    = accept;
        op_o.kind = OP_LOAD_ROM;
        op_o.addr = in_ch.address[OFF_W-1:0];
      end
      CMD_LOAD_MENU: begin
        push_o    = accept;
        op_o.kind = OP_LOAD_MENU;
        op_o.addr = in_ch.address[OFF_W-1:0];
      end
      CMD_BUS_READ: begin
        push_o = accept;
        if (menu && sel_done_q) begin
          op_o.kind = OP_RD_BLANK;
        end else if (in_menu_win) begin
          op_o.kind = OP_RD_MENU;
        end else if (in_trig) begin
          op_o.kind    = OP_SELECT;
          op_o.sel_idx = off[SEL_W-1:0];
        end else if (in_rom) begin
          op_o.kind = OP_RD_ROM;
        end else begin
          op_o.kind = OP_RD_FF;
        end
      end
      default: ;
    endcase
  end

  assign sel_done_d = sel_done_q || (push_o && op_o.kind == OP_SELECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q    <= '0;
      rom_size_q    <= '0;
      entry_count_q <= '0;
      sel_done_q    <= 1'b0;
    end else begin
      map_mode_q    <= map_mode_d;
      rom_size_q    <= rom_size_d;
      entry_count_q <= entry_count_d;
      sel_done_q    <= sel_done_d;
    end
  end

  // once a selection is latched in menu mode no further selection is issued
  a_no_second_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (menu && sel_done_q) |-> !(push_o && op_o.kind == OP_SELECT))
    else $error("second menu selection issued");

  a_sel_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sel_done_q) |-> $past(push_o && op_o.kind == OP_SELECT))
    else $error("selection latched without a selection read");

endmodule

@@ rtl/crbm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_fifo
// Small operation queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module crbm_fifo #(
  parameter int unsigned DEPTH = crbm_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crbm_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output crbm_pkg::op_t  op_o,
  output logic           empty_o
);
  import crbm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  op_t              slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

@@ rtl/crbm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_back
// Executes queued operations: ROM and menu table writes, registered memory
// reads and the result register towards the bus.
// ----------------------------------------------------------------------------
module crbm_back #(
  parameter int unsigned ROM_BYTES = crbm_pkg::ROM_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crbm_pkg::op_t  op_i,
  input  logic           empty_i,
  output logic           pop_o,
  crbm_out_if.source     out_ch
);
  import crbm_pkg::*;

  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);

  logic [BYTE_W-1:0] rom_mem  [ROM_BYTES];
  logic [BYTE_W-1:0] menu_mem [MENU_BYTES];

  logic [BYTE_W-1:0] rom_rd_q, menu_rd_q;
  logic              s1_valid_q, s1_valid_d;
  op_kind_e          s1_kind_q;
  logic [SEL_W-1:0]  s1_idx_q;
  logic              s1_adv, is_read;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic              out_drive_q, out_drive_d;
  logic              out_sel_q, out_sel_d;
  logic [SEL_W-1:0]  out_idx_q, out_idx_d;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign pop_o   = !empty_i && (!s1_valid_q || s1_adv);
  assign is_read = (op_i.kind != OP_LOAD_ROM) && (op_i.kind != OP_LOAD_MENU);

  // memories: write on a load, read at the popped address
  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.kind == OP_LOAD_ROM) begin
      rom_mem[op_i.addr[ROM_AW-1:0]] <= op_i.data;
    end
    if (pop_o) begin
      rom_rd_q <= rom_mem[op_i.addr[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.kind == OP_LOAD_MENU) begin
      menu_mem[op_i.addr[MENU_AW-1:0]] <= op_i.data;
    end
    if (pop_o) begin
      menu_rd_q <= menu_mem[op_i.addr[MENU_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q <= op_i.kind;
      s1_idx_q  <= op_i.sel_idx;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = is_read;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_data_d  = '0;
    out_drive_d = 1'b0;
    out_sel_d   = 1'b0;
    out_idx_d   = '0;
    case (s1_kind_q)
      OP_RD_ROM: begin
        out_data_d  = rom_rd_q;
        out_drive_d = 1'b1;
      end
      OP_RD_MENU: begin
        out_data_d  = menu_rd_q;
        out_drive_d = 1'b1;
      end
      OP_RD_FF: begin
        out_data_d  = BYTE_UNMAPPED;
        out_drive_d = 1'b1;
      end
      OP_SELECT: begin
        out_sel_d = 1'b1;
        out_idx_d = s1_idx_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q  <= out_data_d;
      out_drive_q <= out_drive_d;
      out_sel_q   <= out_sel_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.read_data      = out_data_q;
  assign out_ch.drive          = out_drive_q;
  assign out_ch.selected       = out_sel_q;
  assign out_ch.selected_index = out_idx_q;

  // a read waiting behind a stalled result keeps its data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ch.ready)
      |=> (s1_valid_q && $stable(s1_kind_q) && $stable(rom_rd_q) && $stable(menu_rd_q)))
    else $error("pending read lost while result stalled");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("read advanced without a result");

endmodule

@@ rtl/cartridge_rom_bus_mapper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_rom_bus_mapper_core
// Cartridge responder: loads ROM and menu table bytes and answers bus reads
// with LoROM, HiROM or menu mode mapping.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                     | transaction
//  in_ch    | in  | command, address, load_data                 | valid & ready
//  out_ch   | out | read_data, drive, selected, selected_index  | valid & ready
//  cfg_ch   | in  | addr (register index), data                 | valid & ready
//
//  in_ch takes one transaction per cycle while the queue is not full; a bus
//  read result passes the queue slot written at acceptance, the registered
//  memory read and the result register before it is valid on out_ch
//  the rate is set by the single read port of each memory and the result
//  register: one bus read per cycle while out_ch is ready
//  loads and unused commands produce no result; the queue lets the front keep
//  taking commands for a while when out_ch stalls
//  reset clears control state and registers only; memory contents stay
//  undefined until loaded, with no clearing pass
// ----------------------------------------------------------------------------
module cartridge_rom_bus_mapper_core #(
  parameter int unsigned ROM_BYTES  = crbm_pkg::ROM_BYTES_DEF,
  parameter int unsigned FIFO_DEPTH = crbm_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crbm_in_if.sink     in_ch,
  crbm_cfg_if.sink    cfg_ch,
  crbm_out_if.source  out_ch
);
  import crbm_pkg::*;

  op_t  push_op, pop_op;
  logic push, full, pop, empty;

  crbm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  crbm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (pop_op),
    .empty_o (empty)
  );

  crbm_back #(
    .ROM_BYTES (ROM_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (pop_op),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ test/cartridge_rom_bus_mapper_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_rom_bus_mapper_core_tb
// Drives load and bus read transactions through the mapper under LoROM, HiROM,
// alternate LoROM and menu mappings. A checker class keeps its own image of
// the ROM store, the menu table and the selection latch, predicts the answer
// to each accepted bus read and compares the answers in order.
// ----------------------------------------------------------------------------
module cartridge_rom_bus_mapper_core_tb;
  import crbm_pkg::*;

  localparam int unsigned ROM_BYTES     = crbm_pkg::ROM_BYTES_DEF;
  localparam int unsigned MENU_BASE     = 32'h7000;
  localparam int unsigned TRIG_BASE     = 32'h7400;
  localparam int unsigned OFF_MAX       = 32'h3fffff;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 100;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              drive;
    logic              selected;
    logic [SEL_W-1:0]  sel_index;
  } read_answer_t;

  class cart_read_checker;
    logic [BYTE_W-1:0] rom_img  [int unsigned];
    logic [BYTE_W-1:0] menu_img [int unsigned];
    bit                sel_done;
    map_mode_e         mode;
    int unsigned       rom_size;
    int unsigned       entry_count;
    read_answer_t      answers_due [$];
    int unsigned       mismatches;

    function new();
      sel_done    = 1'b0;
      mode        = MODE_LOROM;
      rom_size    = 0;
      entry_count = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_MAP_MODE:    mode = map_mode_e'(v[MODE_W-1:0]);
        REG_ROM_SIZE:    rom_size = 32'(v);
        REG_ENTRY_COUNT: entry_count = 32'(v[SEL_W-1:0]);
        default: ;
      endcase
    endfunction

    // where a bus read lands under the current mapping
    function op_kind_e classify_read(logic [ADDR_W-1:0] addr, output int unsigned slot);
      logic [OFF_W-1:0] off;
      slot = 0;
      if (mode == MODE_HIROM) off = {addr[21:16], addr[15:0]};
      else off = {addr[22:16], addr[14:0]};
      if (mode == MODE_MENU && sel_done) return OP_RD_BLANK;
      if (mode == MODE_MENU && off >= MENU_BASE && off < TRIG_BASE) begin
        slot = off - MENU_BASE;
        return OP_RD_MENU;
      end
      if (mode == MODE_MENU && off >= TRIG_BASE && off < TRIG_BASE + entry_count) begin
        slot = off - TRIG_BASE;
        return OP_SELECT;
      end
      if (off < rom_size) begin
        slot = off % ROM_BYTES;
        return OP_RD_ROM;
      end
      return OP_RD_FF;
    endfunction

    function void note_command(cmd_e c, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      read_answer_t ans;
      op_kind_e     kind;
      int unsigned  slot;
      case (c)
        CMD_LOAD_ROM:  rom_img[addr % ROM_BYTES] = data;
        CMD_LOAD_MENU: menu_img[addr % MENU_BYTES] = data;
        CMD_BUS_READ: begin
          ans  = '0;
          kind = classify_read(addr, slot);
          case (kind)
            OP_RD_ROM: begin
              ans.read_data = rom_img[slot];
              ans.drive     = 1'b1;
            end
            OP_RD_MENU: begin
              ans.read_data = menu_img[slot];
              ans.drive     = 1'b1;
            end
            OP_RD_FF: begin
              ans.read_data = BYTE_UNMAPPED;
              ans.drive     = 1'b1;
            end
            OP_SELECT: begin
              sel_done      = 1'b1;
              ans.selected  = 1'b1;
              ans.sel_index = SEL_W'(slot);
            end
            default: ;
          endcase
          answers_due.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string what, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_answer(read_answer_t got);
      read_answer_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: answer with none outstanding, got %h", $time, got);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("drive", BYTE_W'(want.drive), BYTE_W'(got.drive));
      compare_field("selected", BYTE_W'(want.selected), BYTE_W'(got.selected));
      compare_field("selected_index", BYTE_W'(want.sel_index), BYTE_W'(got.sel_index));
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  crbm_in_if  in_ch ();
  crbm_cfg_if cfg_ch ();
  crbm_out_if out_ch ();

  cartridge_rom_bus_mapper_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  cart_read_checker sb;
  int unsigned      rom_offsets [$];
  int unsigned      items_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      cycle_count = 0;
  bit               steady = 1'b0;
  bit               hold_pending = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_answer({out_ch.read_data, out_ch.drive, out_ch.selected,
                       out_ch.selected_index});
    end
  end

  // result side back-pressure: changing patterns plus the odd long hold-off
  initial begin : rx_pattern
    int unsigned pat;
    int unsigned left;
    pat  = 0;
    left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          pat  = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (pat)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (left % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [ADDR_W-1:0] bus_addr_of(logic [OFF_W-1:0] off);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom());
    if (sb.mode == MODE_HIROM) begin
      a[21:0] = off;
    end else begin
      a[14:0]  = off[14:0];
      a[22:16] = off[21:15];
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_read_addr();
    logic [ADDR_W-1:0] a;
    int unsigned       off;
    int unsigned       pick;
    int unsigned       slot;
    do begin
      pick = $urandom_range(0, 99);
      off  = $urandom_range(0, 16'hffff);
      if (pick < 40 && rom_offsets.size() != 0) begin
        // revisit loaded bytes, often through a wrapped alias
        off = rom_offsets[$urandom_range(0, rom_offsets.size() - 1)]
              + ROM_BYTES * $urandom_range(0, 7);
      end else if (pick < 55) begin
        off = (sb.rom_size > 2 ? sb.rom_size - 2 : 0) + $urandom_range(0, 3);
      end else if (pick < 80 && sb.mode == MODE_MENU) begin
        if ($urandom_range(0, 1) == 1) off = MENU_BASE - 1 + $urandom_range(0, MENU_BYTES + 1);
        else off = TRIG_BASE + $urandom_range(0, 15);
      end
      if (off > OFF_MAX) off = OFF_MAX;
      a = (pick >= 90) ? ADDR_W'($urandom()) : bus_addr_of(OFF_W'(off));
    end while (sb.classify_read(a, slot) == OP_SELECT);
    return a;
  endfunction

  task automatic send_cmd(cmd_e c, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
    int unsigned gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.address   <= a;
    in_ch.load_data <= d;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (c == CMD_LOAD_ROM && !sb.rom_img.exists(a % ROM_BYTES))
      rom_offsets.push_back(a % ROM_BYTES);
    sb.note_command(c, a, d);
    items_sent++;
  endtask

  task automatic send_read(logic [ADDR_W-1:0] a);
    op_kind_e    kind;
    int unsigned slot;
    kind = sb.classify_read(a, slot);
    // a read never lands on a byte that was never loaded
    if (kind == OP_RD_ROM && !sb.rom_img.exists(slot))
      send_cmd(CMD_LOAD_ROM, ADDR_W'(slot + ROM_BYTES * $urandom_range(0, 31)),
               BYTE_W'($urandom()));
    else if (kind == OP_RD_MENU && !sb.menu_img.exists(slot))
      send_cmd(CMD_LOAD_MENU, ADDR_W'(slot + MENU_BYTES * $urandom_range(0, 16383)),
               BYTE_W'($urandom()));
    send_cmd(CMD_BUS_READ, a, BYTE_W'($urandom()));
  endtask

  // loads give no answer, so allow for them still in flight
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= r;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(r, v);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] mode_word, logic [CFG_DATA_W-1:0] size_word,
                           logic [CFG_DATA_W-1:0] count_word);
    write_reg(REG_MAP_MODE, mode_word);
    write_reg(REG_ROM_SIZE, size_word);
    write_reg(REG_ENTRY_COUNT, count_word);
    // the spare index must leave every register alone
    if ($urandom_range(0, 1) == 1) write_reg(REG_NONE, CFG_DATA_W'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_mix(int unsigned n);
    int unsigned start;
    int unsigned pick;
    bit          held;
    bit          paused;
    start  = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < n) begin
      if (!held && items_sent - start >= n / 3) begin
        // reads keep coming while the result side is held off
        held         = 1'b1;
        hold_pending = 1'b1;
        steady       = 1'b1;
        repeat (30) send_read(pick_read_addr());
        steady       = 1'b0;
      end else if (!paused && items_sent - start >= (2 * n) / 3) begin
        paused = 1'b1;
        drain_results();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_cmd(CMD_LOAD_ROM, ADDR_W'($urandom()), BYTE_W'($urandom()));
        else if (pick < 12) send_cmd(CMD_LOAD_MENU, ADDR_W'($urandom()), BYTE_W'($urandom()));
        else if (pick < 14) send_cmd(CMD_UNUSED, ADDR_W'($urandom()), BYTE_W'($urandom()));
        else send_read(pick_read_addr());
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_LOAD_ROM;
    in_ch.address   <= '0;
    in_ch.load_data <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.addr     <= REG_MAP_MODE;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: empty image, every read answers 0xff
    send_cmd(CMD_BUS_READ, 24'h000000, 8'h00);
    send_cmd(CMD_BUS_READ, 24'hffffff, 8'hff);
    send_cmd(CMD_UNUSED, ADDR_W'($urandom()), BYTE_W'($urandom()));
    send_cmd(CMD_LOAD_ROM, 24'h000000, 8'h00);
    send_cmd(CMD_LOAD_ROM, 24'hffffff, 8'hc3);
    send_cmd(CMD_LOAD_MENU, 24'h000000, 8'hff);
    send_cmd(CMD_LOAD_MENU, 24'hffffff, 8'h5a);

    drain_results();
    configure(CFG_DATA_W'(MODE_LOROM), CFG_DATA_W'(ROM_BYTES), 23'd15);
    send_read(24'h000000);
    send_read(24'h8fffff);
    send_read(24'h108000);
    send_read(24'hffffff);

    drain_results();
    configure(CFG_DATA_W'(MODE_HIROM), 23'h7fffff, 23'h7ffff0);
    send_read(24'hffffff);
    send_read(24'h400000);

    drain_results();
    configure(CFG_DATA_W'(MODE_MENU), CFG_DATA_W'(ROM_BYTES), 23'd0);
    send_read(24'h007000);
    send_read(24'h8073ff);
    send_read(24'h007400);
    send_read(24'h006fff);

    drain_results();
    configure(CFG_DATA_W'(MODE_LOROM), CFG_DATA_W'(ROM_BYTES), 23'd1);
    run_mix(280);

    drain_results();
    configure(CFG_DATA_W'(MODE_HIROM), 23'h7fffff, 23'd3);
    run_mix(280);

    // upper bits of the mode word are dropped, leaving the alternate LoROM code
    drain_results();
    configure(23'h7fffff, CFG_DATA_W'($urandom_range(1, 23'h400000)), 23'h00001f);
    run_mix(230);

    drain_results();
    configure(CFG_DATA_W'(MODE_LOROM), 23'd0, 23'd0);
    run_mix(80);

    drain_results();
    configure(CFG_DATA_W'(MODE_HIROM), 23'h400000, CFG_DATA_W'($urandom_range(0, 15)));
    run_mix(230);

    drain_results();
    configure(CFG_DATA_W'(MODE_MENU), CFG_DATA_W'($urandom_range(1, 23'h7fffff)),
              23'h7ffff0);
    run_mix(230);

    drain_results();
    configure(CFG_DATA_W'(MODE_MENU), CFG_DATA_W'(ROM_BYTES), 23'd15);
    run_mix(230);

    // one selection per run, since only reset clears the latch
    drain_results();
    configure(CFG_DATA_W'(MODE_MENU), CFG_DATA_W'($urandom_range(1, 23'h7fffff)),
              CFG_DATA_W'($urandom_range(1, 15)));
    run_mix(120);
    send_read(bus_addr_of(OFF_W'(TRIG_BASE + $urandom_range(0, sb.entry_count - 1))));
    run_mix(60);

    drain_results();
    configure(CFG_DATA_W'(MODE_LOROM), CFG_DATA_W'($urandom_range(1, ROM_BYTES)),
              CFG_DATA_W'($urandom_range(0, 15)));
    run_mix(90);

    drain_results();
    configure(CFG_DATA_W'(MODE_MENU), CFG_DATA_W'(ROM_BYTES),
              CFG_DATA_W'($urandom_range(0, 15)));
    run_mix(60);

    drain_results();
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/crbm_pkg.sv
rtl/crbm_if.sv
rtl/crbm_front.sv
rtl/crbm_fifo.sv
rtl/crbm_back.sv
rtl/cartridge_rom_bus_mapper_core.sv
test/cartridge_rom_bus_mapper_core_tb.sv
